// File: rtl/core/skht_pkg.sv
// Shared constants, types and codes of the string key hash table.
`timescale 1ns / 1ps
package skht_pkg;

   localparam int TABLE_DEPTH_DEF   = 4096;
   localparam int MAX_KEY_BYTES_DEF = 32;

   localparam int SLOT_W    = 12;
   localparam int ENTRIES_W = 12;
   localparam int STATUS_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int HASH_W    = 32;
   localparam int HASH_KEY_W = 31;
   localparam int TSIZE_W   = 13;
   localparam int STEP_W    = 12;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int MIN_SIZE   = 3;
   localparam int HASH_SHL   = 5;
   localparam int HASH_SHR   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_STEP = 2'd2;

   localparam logic [HASH_W-1:0]  SEED_RST  = 32'd0;
   localparam logic [TSIZE_W-1:0] SIZE_RST  = 13'd4093;
   localparam logic [STEP_W-1:0]  STEP_RST  = 12'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [3:0] {
      PS_CLEAR, PS_IDLE, PS_HOME_MOD, PS_STEP_MOD, PS_META_RD, PS_META_CHK,
      PS_CMP_RD, PS_CMP_CHK, PS_INS_WR, PS_INS_META, PS_FINISH
   } probe_state_type;

   typedef struct packed {
      logic start;
      logic insert;
      logic overlong;
   } key_ctrl_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_W-1:0]    slot;
      logic [STATUS_W-1:0]  status;
      logic [ENTRIES_W-1:0] entries;
   } result_type;

endpackage

// File: rtl/core/skht_ifs.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface skht_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] key_byte;
   logic       key_last;
   modport source (output valid, operation, key_byte, key_last, input ready);
   modport sink   (input valid, operation, key_byte, key_last, output ready);
endinterface

interface skht_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [11:0] slot;
   logic [1:0]  status;
   logic [11:0] entries;
   modport source (output valid, found, slot, status, entries, input ready);
   modport sink   (input valid, found, slot, status, entries, output ready);
endinterface

// File: rtl/core/string_key_hash_table_unit.sv
// Top level of the string key hash table: registers, front end, probe engine, output stage.
`timescale 1ns / 1ps
// Keys stream in one byte per cycle with a last flag while the unit accepts
// bytes; non-final bytes give no response. After the final byte the unit
// computes the home slot and the probe stride with a one-bit-per-cycle
// remainder unit, then probes: it reads the metadata of each slot visited and,
// on a length match, compares the stored key byte by byte; an insert copies
// the key into the key store and then writes the slot metadata. Bytes of the
// next key are taken only once the response of the previous one is loaded
// into the output register. After reset the slot metadata memory is cleared
// before the first byte is taken; configuration writes are taken at any time
// and must only be made while no key is in flight.
module string_key_hash_table_unit #(
   parameter int TABLE_DEPTH   = skht_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   skht_req_if.sink                          req_chan,
   skht_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [skht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [skht_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import skht_pkg::*;

   localparam int BW = $clog2(MAX_KEY_BYTES);
   localparam int LW = $clog2(MAX_KEY_BYTES + 1);

   logic [HASH_W-1:0]  seed_ff, seed_in;
   logic [TSIZE_W-1:0] size_ff, size_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic              byte_en, start_ack, accept_ok, res_valid, out_free;
   logic [BW-1:0]     buf_idx;
   logic [BYTE_W-1:0] buf_byte;
   logic [HASH_W-1:0] key_hash;
   logic [LW-1:0]     key_len;
   key_ctrl_type      key_ctrl;
   result_type        result, rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      seed_in = seed_ff;
      size_in = size_ff;
      step_in = step_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HASH_SEED:  seed_in = csr_wdata[HASH_W-1:0];
            CSR_TABLE_SIZE: size_in = csr_wdata[TSIZE_W-1:0];
            CSR_PROBE_STEP: step_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign byte_en        = req_chan.valid && accept_ok;
   assign req_chan.ready = accept_ok;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   skht_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .operation (req_chan.operation),
      .key_byte  (req_chan.key_byte),
      .key_last  (req_chan.key_last),
      .hash_seed (seed_ff),
      .start_ack (start_ack),
      .buf_idx   (buf_idx),
      .buf_byte  (buf_byte),
      .key_hash  (key_hash),
      .key_len   (key_len),
      .key_ctrl  (key_ctrl)
   );

   skht_probe #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_probe (
      .clock      (clock),
      .reset      (reset),
      .key_ctrl   (key_ctrl),
      .key_hash   (key_hash),
      .key_len    (key_len),
      .buf_byte   (buf_byte),
      .table_size (size_ff),
      .probe_step (step_ff),
      .out_free   (out_free),
      .buf_idx    (buf_idx),
      .start_ack  (start_ack),
      .accept_ok  (accept_ok),
      .res_valid  (res_valid),
      .result     (result)
   );

   always_comb begin
      rsp_in       = res_valid ? result : rsp_ff;
      rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RST;
         size_ff      <= SIZE_RST;
         step_ff      <= STEP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         size_ff      <= size_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.found   = rsp_ff.found;
   assign rsp_chan.slot    = rsp_ff.slot;
   assign rsp_chan.status  = rsp_ff.status;
   assign rsp_chan.entries = rsp_ff.entries;

endmodule

// File: rtl/core/skht_front.sv
// Key byte buffer, byte count and running shift-add-xor hash.
`timescale 1ns / 1ps
module skht_front #(
   parameter int MAX_KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_en,
   input  logic                            operation,
   input  logic [skht_pkg::BYTE_W-1:0]     key_byte,
   input  logic                            key_last,
   input  logic [skht_pkg::HASH_W-1:0]     hash_seed,
   input  logic                            start_ack,
   input  logic [$clog2(MAX_KEY_BYTES)-1:0] buf_idx,
   output logic [skht_pkg::BYTE_W-1:0]     buf_byte,
   output logic [skht_pkg::HASH_W-1:0]     key_hash,
   output logic [$clog2(MAX_KEY_BYTES+1)-1:0] key_len,
   output skht_pkg::key_ctrl_type          key_ctrl
);
   import skht_pkg::*;

   localparam int KW = $clog2(MAX_KEY_BYTES + 2);
   localparam int BW = $clog2(MAX_KEY_BYTES);
   localparam int LW = $clog2(MAX_KEY_BYTES + 1);

   logic [BYTE_W-1:0] buf_mem [MAX_KEY_BYTES];
   logic [KW-1:0]     cnt_ff, cnt_in, len_ff, len_in;
   logic [HASH_W-1:0] hash_ff, hash_in, h_base, c_ext;
   logic              start_ff, start_in, op_ff, op_in;

   always_comb begin
      h_base = (cnt_ff == '0) ? hash_seed : hash_ff;
      c_ext  = {{(HASH_W-BYTE_W){key_byte[BYTE_W-1]}}, key_byte};
      hash_in  = hash_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      op_in    = op_ff;
      start_in = start_ff & ~start_ack;
      if (byte_en) begin
         hash_in = h_base ^ ((h_base << HASH_SHL) + c_ext + (h_base >> HASH_SHR));
         cnt_in  = (cnt_ff < KW'(MAX_KEY_BYTES)) ? cnt_ff + KW'(1) : KW'(MAX_KEY_BYTES + 1);
         if (key_last) begin
            len_in   = cnt_in;
            cnt_in   = '0;
            op_in    = operation;
            start_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         start_ff <= start_in;
      end
      hash_ff <= hash_in;
      len_ff  <= len_in;
      op_ff   <= op_in;
      if (byte_en && cnt_ff < KW'(MAX_KEY_BYTES)) begin
         buf_mem[cnt_ff[BW-1:0]] <= key_byte;
      end
   end

   assign buf_byte          = buf_mem[buf_idx];
   assign key_hash          = hash_ff;
   assign key_len           = LW'(len_ff);
   assign key_ctrl.start    = start_ff;
   assign key_ctrl.insert   = op_ff;
   assign key_ctrl.overlong = (len_ff > KW'(MAX_KEY_BYTES));

endmodule

// File: rtl/core/skht_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module skht_mod #(
   parameter int SW = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [skht_pkg::HASH_KEY_W-1:0]   dividend,
   input  logic [SW-1:0]                     divisor,
   output logic                              done,
   output logic [SW-1:0]                     remainder
);
   import skht_pkg::*;

   localparam int CNT_W = $clog2(HASH_KEY_W);

   logic [HASH_KEY_W-1:0] dvd_ff, dvd_in;
   logic [SW-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [SW:0]           trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[HASH_KEY_W-1]};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor}) ? SW'(trial - {1'b0, divisor}) : SW'(trial);
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(HASH_KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/skht_probe.sv
// Probe sequencer with the slot metadata memory and the key store memory.
`timescale 1ns / 1ps
module skht_probe #(
   parameter int TABLE_DEPTH   = skht_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_KEY_BYTES = skht_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  skht_pkg::key_ctrl_type             key_ctrl,
   input  logic [skht_pkg::HASH_W-1:0]        key_hash,
   input  logic [$clog2(MAX_KEY_BYTES+1)-1:0] key_len,
   input  logic [skht_pkg::BYTE_W-1:0]        buf_byte,
   input  logic [skht_pkg::TSIZE_W-1:0]       table_size,
   input  logic [skht_pkg::STEP_W-1:0]        probe_step,
   input  logic                               out_free,
   output logic [$clog2(MAX_KEY_BYTES)-1:0]   buf_idx,
   output logic                               start_ack,
   output logic                               accept_ok,
   output logic                               res_valid,
   output skht_pkg::result_type               result
);
   import skht_pkg::*;

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int SW  = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = (SW > TSIZE_W) ? SW : TSIZE_W;
   localparam int BW  = $clog2(MAX_KEY_BYTES);
   localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
   localparam int KSW = $clog2(TABLE_DEPTH * MAX_KEY_BYTES);

   probe_state_type state_ff, state_in;

   logic [LW:0]       meta_mem [TABLE_DEPTH];
   logic [BYTE_W-1:0] key_mem  [TABLE_DEPTH * MAX_KEY_BYTES];
   logic [LW:0]       meta_q_ff, meta_wdata;
   logic [BYTE_W-1:0] key_q_ff;
   logic              meta_we, key_we;
   logic [AW-1:0]     meta_waddr;
   logic [KSW-1:0]    key_addr;

   logic [AW-1:0]       addr_ff, addr_in, home_ff, home_in, step_ff, step_in;
   logic [AW-1:0]       occ_ff, occ_in, clr_ff, clr_in, slot_ff, slot_in;
   logic [SW-1:0]       n_ff, n_in, size_eff;
   logic [BW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0]         ts_ext;
   logic [STEP_W-1:0]     step_eff;
   logic                  mod_start, mod_done;
   logic [HASH_KEY_W-1:0] mod_dvd;
   logic [SW-1:0]         mod_rem;
   logic [SW:0]           sum_w, wrap_w;
   logic                  last_idx;

   always_comb begin
      ts_ext = CW'(table_size);
      if (ts_ext < CW'(MIN_SIZE)) begin
         size_eff = SW'(MIN_SIZE);
      end else if (ts_ext > CW'(TABLE_DEPTH)) begin
         size_eff = SW'(TABLE_DEPTH);
      end else begin
         size_eff = SW'(ts_ext);
      end
      step_eff = (probe_step == '0) ? STEP_W'(1) : probe_step;
      sum_w    = (SW+1)'(addr_ff) + (SW+1)'(step_ff);
      wrap_w   = (sum_w >= (SW+1)'(size_eff)) ? sum_w - (SW+1)'(size_eff) : sum_w;
      last_idx = (idx_ff == BW'(key_len - LW'(1)));
      key_addr = KSW'(addr_ff) * KSW'(MAX_KEY_BYTES) + KSW'(idx_ff);
   end

   skht_mod #(.SW(SW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dvd),
      .divisor   (size_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_CLEAR:    if (clr_ff == AW'(TABLE_DEPTH - 1)) state_in = PS_IDLE;
         PS_IDLE: begin
            if (key_ctrl.start) state_in = key_ctrl.overlong ? PS_FINISH : PS_HOME_MOD;
         end
         PS_HOME_MOD: if (mod_done) state_in = PS_STEP_MOD;
         PS_STEP_MOD: if (mod_done) state_in = PS_META_RD;
         PS_META_RD:  state_in = (n_ff == size_eff) ? PS_FINISH : PS_META_CHK;
         PS_META_CHK: begin
            if (!meta_q_ff[LW]) begin
               if (key_ctrl.insert == OP_INSERT && SW'(occ_ff) < size_eff - SW'(1)) begin
                  state_in = PS_INS_WR;
               end else begin
                  state_in = PS_FINISH;
               end
            end else if (meta_q_ff[LW-1:0] == key_len) begin
               state_in = PS_CMP_RD;
            end else begin
               state_in = PS_META_RD;
            end
         end
         PS_CMP_RD:   state_in = PS_CMP_CHK;
         PS_CMP_CHK: begin
            if (key_q_ff != buf_byte) state_in = PS_META_RD;
            else if (last_idx)        state_in = PS_FINISH;
            else                      state_in = PS_CMP_RD;
         end
         PS_INS_WR:   if (last_idx) state_in = PS_INS_META;
         PS_INS_META: state_in = PS_FINISH;
         PS_FINISH:   if (out_free) state_in = PS_IDLE;
         default:     state_in = PS_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      addr_in    = addr_ff;
      home_in    = home_ff;
      step_in    = step_ff;
      occ_in     = occ_ff;
      clr_in     = clr_ff;
      slot_in    = slot_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      mod_start  = 1'b0;
      mod_dvd    = HASH_KEY_W'(step_eff);
      meta_we    = 1'b0;
      meta_waddr = addr_ff;
      meta_wdata = {1'b1, key_len};
      key_we     = 1'b0;
      start_ack  = 1'b0;
      res_valid  = 1'b0;
      case (state_ff)
         PS_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + AW'(1);
         end
         PS_IDLE: begin
            if (key_ctrl.start) begin
               start_ack = 1'b1;
               found_in  = 1'b0;
               if (key_ctrl.overlong) begin
                  slot_in   = '0;
                  status_in = STATUS_TOO_LONG;
               end else begin
                  mod_start = 1'b1;
                  mod_dvd   = key_hash[HASH_KEY_W-1:0];
               end
            end
         end
         PS_HOME_MOD: begin
            if (mod_done) begin
               home_in   = AW'(mod_rem);
               addr_in   = AW'(mod_rem);
               mod_start = 1'b1;
            end
         end
         PS_STEP_MOD: begin
            if (mod_done) begin
               step_in = AW'(mod_rem);
               n_in    = '0;
            end
         end
         PS_META_RD: begin
            idx_in = '0;
            if (n_ff == size_eff) begin
               slot_in   = home_ff;
               status_in = STATUS_FULL;
            end
         end
         PS_META_CHK: begin
            if (!meta_q_ff[LW]) begin
               slot_in   = addr_ff;
               status_in = (key_ctrl.insert == OP_INSERT && SW'(occ_ff) >= size_eff - SW'(1))
                           ? STATUS_FULL : STATUS_OK;
            end else if (meta_q_ff[LW-1:0] != key_len) begin
               addr_in = AW'(wrap_w);
               n_in    = n_ff + SW'(1);
            end
         end
         PS_CMP_CHK: begin
            if (key_q_ff != buf_byte) begin
               addr_in = AW'(wrap_w);
               n_in    = n_ff + SW'(1);
            end else if (last_idx) begin
               found_in  = 1'b1;
               slot_in   = addr_ff;
               status_in = STATUS_OK;
            end else begin
               idx_in = idx_ff + BW'(1);
            end
         end
         PS_INS_WR: begin
            key_we = 1'b1;
            if (!last_idx) idx_in = idx_ff + BW'(1);
         end
         PS_INS_META: begin
            meta_we = 1'b1;
            occ_in  = occ_ff + AW'(1);
         end
         PS_FINISH:   res_valid = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_CLEAR;
         clr_ff   <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         occ_ff   <= occ_in;
      end
      addr_ff   <= addr_in;
      home_ff   <= home_in;
      step_ff   <= step_in;
      slot_ff   <= slot_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_q_ff <= meta_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_addr] <= buf_byte;
      key_q_ff <= key_mem[key_addr];
   end

   assign buf_idx        = idx_ff;
   assign accept_ok      = (state_ff == PS_IDLE) && !key_ctrl.start;
   assign result.found   = found_ff;
   assign result.slot    = SLOT_W'(slot_ff);
   assign result.status  = status_ff;
   assign result.entries = ENTRIES_W'(occ_ff);

endmodule

// File: rtl/core/skht_checker.sv
// Port-level checks on the hash table unit, bound to the top level.
`timescale 1ns / 1ps
module skht_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_found,
   input logic [skht_pkg::SLOT_W-1:0]     rsp_slot,
   input logic [skht_pkg::STATUS_W-1:0]   rsp_status,
   input logic [skht_pkg::ENTRIES_W-1:0]  rsp_entries
);
   import skht_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_entries))
      else $error("response item changed while stalled");

   a_too_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TOO_LONG |-> !rsp_found && rsp_slot == '0)
      else $error("overlong key reported a slot or a hit");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("hit reported with an error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                    rsp_status == STATUS_TOO_LONG)
      else $error("undefined status code");

endmodule

bind string_key_hash_table_unit skht_checker u_skht_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_found   (rsp_chan.found),
   .rsp_slot    (rsp_chan.slot),
   .rsp_status  (rsp_chan.status),
   .rsp_entries (rsp_chan.entries)
);

// File: tb/sv/string_key_hash_table_unit_test.sv
// Self-checking testbench for the string key hash table unit.
`timescale 1ns / 1ps
module string_key_hash_table_unit_test;
   import skht_pkg::*;

   localparam int DEPTH   = TABLE_DEPTH_DEF;
   localparam int MAXK    = MAX_KEY_BYTES_DEF;
   localparam int LONGEST = 40;
   localparam int SETTLE  = 300;

   typedef logic [LONGEST-1:0][7:0] key_bytes_t;
   typedef struct {
      key_bytes_t bytes;
      int         len;
   } word_t;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   skht_req_if req();
   skht_rsp_if rsp();

   string_key_hash_table_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // table mirror
   logic [HASH_W-1:0]    seed_q;
   logic [TSIZE_W-1:0]   size_q;
   logic [STEP_W-1:0]    step_q;
   logic [HASH_W-1:0]    run_hash;
   int                   byte_count;
   logic [7:0]           key_buf [MAXK];
   logic                 slot_used [DEPTH];
   int                   slot_len [DEPTH];
   logic [7:0]           slot_bytes [DEPTH][MAXK];
   logic [ENTRIES_W-1:0] used_count;

   result_type expected_results[$];
   word_t      word_pool[$];
   int         error_count;
   int         snd_idle_pct;
   int         rcv_idle_pct;
   int         hold_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic bit table_step(input logic op, input logic [7:0] b, input logic last,
                                     output result_type r);
      logic [31:0] c, h, size, step, home, addr;
      int len;
      bit hit, empty, same;
      hit = 0;
      empty = 0;
      if (byte_count == 0) run_hash = seed_q;
      c = {{24{b[7]}}, b};
      h = run_hash;
      h = h ^ ((h << HASH_SHL) + c + (h >> HASH_SHR));
      run_hash = h;
      if (byte_count < MAXK) begin
         key_buf[byte_count] = b;
         byte_count++;
      end else begin
         byte_count = MAXK + 1;
      end
      if (!last) return 0;
      len = byte_count;
      byte_count = 0;
      r.found = 1'b0;
      r.slot = '0;
      r.status = STATUS_OK;
      r.entries = used_count;
      if (len > MAXK) begin
         r.status = STATUS_TOO_LONG;
         return 1;
      end
      size = size_q < MIN_SIZE ? MIN_SIZE : (size_q > DEPTH ? DEPTH : size_q);
      step = step_q == 0 ? 1 : step_q;
      home = (h & 32'h7fff_ffff) % size;
      addr = home;
      for (int n = 0; n < size; n++) begin
         if (!slot_used[addr]) begin
            empty = 1;
            break;
         end
         if (slot_len[addr] == len) begin
            same = 1;
            for (int i = 0; i < len; i++)
               if (slot_bytes[addr][i] != key_buf[i]) same = 0;
            if (same) begin
               hit = 1;
               break;
            end
         end
         addr = (addr + step) % size;
      end
      if (hit) begin
         r.found = 1'b1;
         r.slot = addr[SLOT_W-1:0];
      end else if (!empty) begin
         r.slot = home[SLOT_W-1:0];
         r.status = STATUS_FULL;
      end else begin
         r.slot = addr[SLOT_W-1:0];
         if (op == OP_INSERT) begin
            if (used_count >= size - 1) begin
               r.status = STATUS_FULL;
            end else begin
               for (int i = 0; i < len; i++) slot_bytes[addr][i] = key_buf[i];
               slot_len[addr] = len;
               slot_used[addr] = 1'b1;
               used_count++;
               r.entries = used_count;
            end
         end
      end
      return 1;
   endfunction

   // entered and left at a falling edge
   task automatic send_byte(input logic op, input logic [7:0] b, input logic last);
      result_type r;
      while ($urandom_range(99) < snd_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.operation = op;
      req.key_byte = b;
      req.key_last = last;
      do @(posedge clock); while (!req.ready);
      if (table_step(op, b, last, r)) expected_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic send_word(input logic op, input word_t w);
      for (int i = 0; i < w.len; i++) send_byte(op, w.bytes[i], i == w.len - 1);
      req.valid = 1'b0;
   endtask

   function automatic word_t fresh_word(input int len);
      word_t w;
      for (int i = 0; i < LONGEST; i++) w.bytes[i] = $urandom_range(255);
      w.len = len;
      return w;
   endfunction

   task automatic wait_drained();
      req.valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         CSR_HASH_SEED:  seed_q = val;
         CSR_TABLE_SIZE: size_q = val[TSIZE_W-1:0];
         CSR_PROBE_STEP: step_q = val[STEP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp.ready = 1'b0;
         hold_left--;
      end else begin
         rsp.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected item: slot %0d status %0d", rsp.slot, rsp.status);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp.found !== e.found) begin
               $error("found: expected %0d, got %0d", e.found, rsp.found);
               error_count++;
            end
            if (rsp.slot !== e.slot) begin
               $error("slot: expected %0d, got %0d", e.slot, rsp.slot);
               error_count++;
            end
            if (rsp.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp.status);
               error_count++;
            end
            if (rsp.entries !== e.entries) begin
               $error("entries: expected %0d, got %0d", e.entries, rsp.entries);
               error_count++;
            end
         end
      end
   end

   task automatic test_byte_extremes();
      word_t w;
      logic [7:0] pat [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
      foreach (pat[p]) begin
         w = fresh_word(1);
         w.bytes[0] = pat[p];
         send_word(OP_LOOKUP, w);
         send_word(OP_INSERT, w);
         send_word(OP_LOOKUP, w);
         word_pool.push_back(w);
      end
      w = fresh_word(MAXK);
      send_word(OP_INSERT, w);
      send_word(OP_LOOKUP, w);
      word_pool.push_back(w);
   endtask

   task automatic test_overlong_keys();
      send_word(OP_INSERT, fresh_word(MAXK + 1));
      send_word(OP_LOOKUP, fresh_word(LONGEST));
   endtask

   task automatic test_seed_and_saturation();
      write_csr(CSR_HASH_SEED, 32'hffff_ffff);
      write_csr(CSR_TABLE_SIZE, 32'd8191);
      write_csr(CSR_PROBE_STEP, 32'd0);
      for (int i = 0; i < 3; i++) send_word(OP_INSERT, word_pool[i]);
      write_csr(CSR_TABLE_SIZE, 32'd0);
      write_csr(CSR_PROBE_STEP, 32'd4095);
      for (int i = 0; i < 3; i++) send_word(OP_LOOKUP, word_pool[i]);
   endtask

   task automatic test_table_full();
      write_csr(CSR_TABLE_SIZE, 32'd16);
      write_csr(CSR_PROBE_STEP, 32'd1);
      for (int i = 0; i < 20; i++) send_word(OP_INSERT, fresh_word($urandom_range(1, 6)));
   endtask

   // shrinking over a crowded table leaves no empty slot to stop the probe
   task automatic test_probe_exhausted();
      write_csr(CSR_TABLE_SIZE, 32'd3);
      for (int i = 0; i < 4; i++) send_word(i[0], fresh_word($urandom_range(1, 4)));
      write_csr(CSR_TABLE_SIZE, 32'd4096);
   endtask

   task automatic test_random_traffic(input int n_bytes);
      int sent;
      int pick;
      word_t w;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 55 && word_pool.size() != 0) begin
            w = word_pool[$urandom_range(word_pool.size() - 1)];
         end else if (pick < 97) begin
            w = fresh_word($urandom_range(0, 3) == 0 ? $urandom_range(1, MAXK)
                                                    : $urandom_range(1, 8));
            word_pool.push_back(w);
         end else begin
            w = fresh_word($urandom_range(MAXK + 1, LONGEST));
         end
         send_word($urandom_range(1), w);
         sent += w.len;
      end
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 400;
      @(negedge clock);
      for (int i = 0; i < 12; i++) send_word(OP_INSERT, fresh_word($urandom_range(1, 5)));
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = OP_LOOKUP;
      req.key_byte = '0;
      req.key_last = 1'b0;
      rsp.ready = 1'b0;
      error_count = 0;
      hold_left = 0;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      seed_q = SEED_RST;
      size_q = SIZE_RST;
      step_q = STEP_RST;
      run_hash = SEED_RST;
      byte_count = 0;
      used_count = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      snd_idle_pct = 8;
      rcv_idle_pct = 53;
      test_byte_extremes();
      test_overlong_keys();
      test_seed_and_saturation();
      test_table_full();
      test_probe_exhausted();
      test_backpressure();

      write_csr(CSR_HASH_SEED, $urandom);
      write_csr(CSR_TABLE_SIZE, 32'd61);
      write_csr(CSR_PROBE_STEP, 32'd7);
      test_random_traffic(650);

      snd_idle_pct = 53;
      rcv_idle_pct = 8;
      write_csr(CSR_HASH_SEED, 32'h0);
      write_csr(CSR_TABLE_SIZE, 32'd509);
      write_csr(CSR_PROBE_STEP, 32'd2);
      test_random_traffic(650);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_csr(CSR_HASH_SEED, $urandom);
      write_csr(CSR_TABLE_SIZE, 32'd4096);
      write_csr(CSR_PROBE_STEP, 32'd4095);
      test_random_traffic(650);
      test_backpressure();

      wait_drained();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
